>>> hw/rtl/rpuf_pkg.sv
// ----------------------------------------------------------------------------
// rpuf_pkg
// Shared constants of the rollback parity union-find unit.
// ----------------------------------------------------------------------------
package rpuf_pkg;

   localparam int DEF_MAX_VERTICES = 1024;
   localparam int DEF_COLORS       = 4;

   localparam int FIELD_W  = 11;   // width of node, depth and count fields
   localparam int OPCODE_W = 2;
   localparam int COLOR_W  = 3;

   localparam logic [OPCODE_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_TEST = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ROLL = 2'd2;

   // request word: opcode, color, node_a, node_b, target_depth (38 bits -> 40)
   localparam int REQ_W = 40;
   // result word: conflict, depth_now (12 bits -> 16)
   localparam int RSP_W = 16;

endpackage

>>> hw/rtl/rollback_parity_union_find_unit.sv
// ----------------------------------------------------------------------------
// rollback_parity_union_find_unit
// Union-find per color over doubled vertex copies, with undo stack rollback
// and an odd-cycle test.
// ----------------------------------------------------------------------------
// channel | dir | handshake      | payload
// req     | in  | tvalid/tready  | opcode, color, node_a, node_b, target_depth
// rsp     | out | tvalid/tready  | conflict, depth_now
// csr     | in  | wr_en          | vertex_count
// One request at a time. Each find step takes a read state and a check state
// (node memory read data is registered). An add runs two union passes, each
// writing child and root on a real union; a rollback pops records through
// S_PRD, S_PCHK and S_PWR2. After reset a clearing pass over the node memory
// holds req_tready low. A stalled result holds in its register; the next
// request waits for it.
// ----------------------------------------------------------------------------
module rollback_parity_union_find_unit #(
   parameter int MAX_VERTICES = rpuf_pkg::DEF_MAX_VERTICES,
   parameter int COLORS       = rpuf_pkg::DEF_COLORS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [1:0] opcode, [4:2] color, [15:5] node_a, [26:16] node_b,
   // [37:27] target_depth, [39:38] zero
   input  logic [rpuf_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] conflict, [11:1] depth_now, [15:12] zero
   output logic [rpuf_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_wr_en,
   input  logic [rpuf_pkg::FIELD_W-1:0] csr_wr_data
);
   import rpuf_pkg::*;

   localparam int NODES  = 2 * MAX_VERTICES;
   localparam int NODE_W = $clog2(NODES);
   localparam int CI_W   = (COLORS > 1) ? $clog2(COLORS) : 1;
   localparam int ADDR_W = NODE_W + CI_W;
   localparam int DEP_W  = NODE_W + 1;
   localparam int CNT_W  = $clog2(NODES + 1) + 1;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_FRD   = 10'b0000000010,
      S_FCHK  = 10'b0000000100,
      S_JOIN  = 10'b0000001000,
      S_JWR2  = 10'b0000010000,
      S_NEXT  = 10'b0000100000,
      S_PRD   = 10'b0001000000,
      S_PCHK  = 10'b0010000000,
      S_PWR2  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type          st_ff, st_in;
   logic [FIELD_W-1:0] vcnt_ff, vcnt_in;
   logic [DEP_W-1:0]   depth_ff [COLORS];
   logic [DEP_W-1:0]   depth_in [COLORS];

   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [CI_W-1:0]    ci_ff, ci_in;
   logic [NODE_W-1:0]  a_ff, a_in, b_ff, b_in;      // operand nodes of this pass
   logic [NODE_W-1:0]  cur_ff, cur_in;              // find cursor
   logic [NODE_W-1:0]  x_ff, x_in;                  // first root
   logic [3:0]         xr_ff, xr_in, yr_in, yr_ff;
   logic               second_ff, second_in;        // finding b
   logic               pass_ff, pass_in;            // second union of add
   logic [FIELD_W-1:0] tgt_ff, tgt_in;
   logic [NODE_W-1:0]  pu_ff, pu_in, pv_ff, pv_in;  // u-1 and v-1
   logic [FIELD_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0]   steps_ff, steps_in;
   logic               conf_ff, conf_in;
   logic               ovalid_ff, ovalid_in;
   logic [RSP_W-1:0]   odata_ff, odata_in;

   logic [ADDR_W-1:0]  s_rd_addr, s_wr_addr, u_rd_addr, u_wr_addr;
   logic [NODE_W-1:0]  s_rd_parent, s_wr_parent, u_rd_child, u_rd_root;
   logic [3:0]         s_rd_rank, s_wr_rank;
   logic               s_wr_en, u_wr_en, u_rd_bump, clear_busy;
   logic [NODE_W-1:0]  u_wr_child, u_wr_root;
   logic               u_wr_bump;

   rpuf_store #(.ADDR_W(ADDR_W), .NODE_W(NODE_W)) u_store (
      .clock, .reset, .rd_addr(s_rd_addr), .rd_parent(s_rd_parent),
      .rd_rank(s_rd_rank), .wr_en(s_wr_en), .wr_addr(s_wr_addr),
      .wr_parent(s_wr_parent), .wr_rank(s_wr_rank), .clear_busy
   );

   rpuf_undo #(.ADDR_W(ADDR_W), .NODE_W(NODE_W)) u_undo (
      .clock, .rd_addr(u_rd_addr), .rd_child(u_rd_child), .rd_root(u_rd_root),
      .rd_bump(u_rd_bump), .wr_en(u_wr_en), .wr_addr(u_wr_addr),
      .wr_child(u_wr_child), .wr_root(u_wr_root), .wr_bump(u_wr_bump)
   );

   logic [OPCODE_W-1:0] r_op;
   logic [COLOR_W-1:0]  r_color;
   logic [FIELD_W-1:0]  r_a, r_b, r_tgt, n_eff;
   logic                color_ok, ends_ok;
   logic [DEP_W-1:0]    cdepth;
   logic [NODE_W-1:0]   lo, hi, y_root;
   logic [3:0]          lo_r, hi_r;
   logic                bump;

   assign r_op    = req_tdata[1:0];
   assign r_color = req_tdata[4:2];
   assign r_a     = req_tdata[15:5];
   assign r_b     = req_tdata[26:16];
   assign r_tgt   = req_tdata[37:27];
   assign n_eff   = (32'(vcnt_ff) > MAX_VERTICES) ? FIELD_W'(MAX_VERTICES) : vcnt_ff;
   assign color_ok = (r_color != '0) && (32'(r_color) <= COLORS);
   assign ends_ok  = (r_a != '0) && (r_a <= n_eff) && (r_b != '0) && (r_b <= n_eff);
   assign cdepth   = depth_ff[ci_ff];
   assign req_tready = (st_ff == S_IDLE) && !clear_busy && !ovalid_ff;
   assign y_root   = cur_ff;

   // union by rank between x (first root) and y (cursor root)
   always_comb begin
      if (xr_ff > yr_ff) begin
         lo = y_root; lo_r = yr_ff; hi = x_ff; hi_r = xr_ff;
      end else begin
         lo = x_ff; lo_r = xr_ff; hi = y_root; hi_r = yr_ff;
      end
      bump = (lo_r == hi_r);
   end

   always_comb begin
      st_in = st_ff; vcnt_in = vcnt_ff; depth_in = depth_ff;
      op_in = op_ff; ci_in = ci_ff; a_in = a_ff; b_in = b_ff; cur_in = cur_ff;
      x_in = x_ff; xr_in = xr_ff; yr_in = yr_ff; second_in = second_ff;
      pass_in = pass_ff; tgt_in = tgt_ff; pu_in = pu_ff; pv_in = pv_ff;
      n_in = n_ff; steps_in = steps_ff; conf_in = conf_ff;
      ovalid_in = ovalid_ff; odata_in = odata_ff;
      s_rd_addr = {ci_ff, cur_ff}; s_wr_en = 1'b0; s_wr_addr = {ci_ff, lo};
      s_wr_parent = hi; s_wr_rank = lo_r;
      u_rd_addr = {ci_ff, cdepth[NODE_W-1:0] - 1'b1};
      u_wr_en = 1'b0; u_wr_addr = {ci_ff, cdepth[NODE_W-1:0]};
      u_wr_child = lo; u_wr_root = hi; u_wr_bump = bump;

      if (csr_wr_en) vcnt_in = csr_wr_data;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = r_op; tgt_in = r_tgt; conf_in = 1'b0;
               ci_in = CI_W'(r_color - 1'b1);
               n_in = n_eff;
               pu_in = NODE_W'(r_a - 1'b1); pv_in = NODE_W'(r_b - 1'b1);
               pass_in = 1'b0; second_in = 1'b0; steps_in = '0;
               if (!color_ok) begin
                  ovalid_in = 1'b1; odata_in = '0;
               end else if ((r_op == OP_ADD || r_op == OP_TEST) && ends_ok) begin
                  a_in = NODE_W'(r_a - 1'b1);
                  b_in = (r_op == OP_ADD) ? NODE_W'(r_b - 1'b1 + n_eff)
                                          : NODE_W'(r_b - 1'b1);
                  cur_in = NODE_W'(r_a - 1'b1);
                  st_in = S_FRD;
               end else if (r_op == OP_ROLL) begin
                  st_in = S_NEXT;
               end else begin
                  st_in = S_DONE;
               end
            end
         end
         S_FRD: begin
            s_rd_addr = {ci_ff, cur_ff};
            st_in = S_FCHK;
         end
         S_FCHK: begin
            if (s_rd_parent != cur_ff && 32'(steps_ff) < NODES) begin
               cur_in = s_rd_parent; steps_in = steps_ff + 1'b1; st_in = S_FRD;
            end else if (!second_ff) begin
               x_in = cur_ff; xr_in = s_rd_rank; second_in = 1'b1;
               cur_in = b_ff; steps_in = '0; st_in = S_FRD;
            end else begin
               yr_in = s_rd_rank;
               if (op_ff == OP_TEST) begin
                  conf_in = (x_ff == cur_ff); st_in = S_DONE;
               end else if (x_ff == cur_ff || 32'(cdepth) >= NODES) begin
                  st_in = S_NEXT;
               end else begin
                  st_in = S_JOIN;
               end
            end
         end
         S_JOIN: begin
            // child points to root, keep its own rank; push undo record
            s_wr_en = 1'b1; s_wr_addr = {ci_ff, lo}; s_wr_parent = hi;
            s_wr_rank = lo_r;
            u_wr_en = 1'b1;
            depth_in[ci_ff] = cdepth + 1'b1;
            st_in = S_JWR2;
         end
         S_JWR2: begin
            s_wr_en = 1'b1; s_wr_addr = {ci_ff, hi}; s_wr_parent = hi;
            s_wr_rank = hi_r + 4'(bump);
            st_in = S_NEXT;
         end
         S_NEXT: begin
            if (op_ff == OP_ADD) begin
               if (!pass_ff) begin
                  pass_in = 1'b1; second_in = 1'b0; steps_in = '0;
                  a_in = NODE_W'(pu_ff + n_ff); b_in = pv_ff;
                  cur_in = NODE_W'(pu_ff + n_ff);
                  st_in = S_FRD;
               end else begin
                  st_in = S_DONE;
               end
            end else if (cdepth > DEP_W'(tgt_ff)) begin
               u_rd_addr = {ci_ff, cdepth[NODE_W-1:0] - 1'b1};
               st_in = S_PRD;
            end else begin
               st_in = S_DONE;
            end
         end
         S_PRD: begin
            // undo data valid; fetch the child's entry
            s_rd_addr = {ci_ff, u_rd_child};
            st_in = S_PCHK;
         end
         S_PCHK: begin
            // make the child a root again with its own rank; fetch the root
            s_rd_addr = {ci_ff, u_rd_root};
            s_wr_en = 1'b1; s_wr_addr = {ci_ff, u_rd_child};
            s_wr_parent = u_rd_child; s_wr_rank = s_rd_rank;
            st_in = S_PWR2;
         end
         S_PWR2: begin
            // drop the rank bump of the root
            s_wr_en = 1'b1; s_wr_addr = {ci_ff, u_rd_root}; s_wr_parent = s_rd_parent;
            s_wr_rank = s_rd_rank - 4'(u_rd_bump);
            depth_in[ci_ff] = cdepth - 1'b1;
            st_in = S_NEXT;
         end
         S_DONE: begin
            ovalid_in = 1'b1;
            odata_in = RSP_W'({cdepth[FIELD_W-1:0], conf_ff});
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vcnt_ff <= FIELD_W'(MAX_VERTICES < 1024 ? MAX_VERTICES : 1024);
         for (int i = 0; i < COLORS; i++) depth_ff[i] <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vcnt_ff <= vcnt_in; depth_ff <= depth_in;
         ovalid_ff <= ovalid_in;
      end
      op_ff <= op_in; ci_ff <= ci_in; a_ff <= a_in; b_ff <= b_in; cur_ff <= cur_in;
      x_ff <= x_in; xr_ff <= xr_in; yr_ff <= yr_in; second_ff <= second_in;
      pass_ff <= pass_in; tgt_ff <= tgt_in; pu_ff <= pu_in; pv_ff <= pv_in;
      n_ff <= n_in; steps_ff <= steps_in; conf_ff <= conf_in; odata_ff <= odata_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_tready) else $error("request taken during clear");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result dropped");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("overlap");
endmodule

>>> hw/rtl/rpuf_store.sv
// ----------------------------------------------------------------------------
// rpuf_store
// Node memory: parent and rank per node of all forests, one read and one
// write port, registered read data, clearing sweep after reset.
// ----------------------------------------------------------------------------
module rpuf_store #(
   parameter int ADDR_W = 13,
   parameter int NODE_W = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [NODE_W-1:0] rd_parent,
   output logic [3:0]        rd_rank,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [NODE_W-1:0] wr_parent,
   input  logic [3:0]        wr_rank,
   output logic              clear_busy
);
   import rpuf_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [NODE_W+3:0] mem [DEPTH];
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              busy_ff, busy_in;
   logic [NODE_W+3:0] rd_ff;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (reset) begin
         clr_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == ADDR_W'(DEPTH - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff  <= clr_in;
      busy_ff <= busy_in;
   end

   // each node points to itself, rank one; node index is the low bits
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= {clr_ff[NODE_W-1:0], 4'd1};
      end else if (wr_en) begin
         mem[wr_addr] <= {wr_parent, wr_rank};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_parent  = rd_ff[NODE_W+3:4];
   assign rd_rank    = rd_ff[3:0];
   assign clear_busy = busy_ff;
endmodule

>>> hw/rtl/rpuf_undo.sv
// ----------------------------------------------------------------------------
// rpuf_undo
// Undo record memory: child, root and rank bump per stack slot of each color.
// ----------------------------------------------------------------------------
module rpuf_undo #(
   parameter int ADDR_W = 13,
   parameter int NODE_W = 11
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [NODE_W-1:0] rd_child,
   output logic [NODE_W-1:0] rd_root,
   output logic              rd_bump,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [NODE_W-1:0] wr_child,
   input  logic [NODE_W-1:0] wr_root,
   input  logic              wr_bump
);
   import rpuf_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;
   localparam int W = 2 * NODE_W + 1;

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= {wr_child, wr_root, wr_bump};
      rd_ff <= mem[rd_addr];
   end

   assign rd_child = rd_ff[W-1 -: NODE_W];
   assign rd_root  = rd_ff[NODE_W:1];
   assign rd_bump  = rd_ff[0];
endmodule

>>> tb/tb_rollback_parity_union_find_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rollback_parity_union_find_unit
// Drives add, test and rollback requests into the union-find unit under
// several vertex counts and handshake idling phases, and checks each result
// against a local parity union-find model with per-color undo stacks.
// ----------------------------------------------------------------------------
module tb_rollback_parity_union_find_unit;
   import rpuf_pkg::*;

   localparam int NV    = DEF_MAX_VERTICES;
   localparam int NC    = DEF_COLORS;
   localparam int NODES = 2 * NV;
   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_wr_en = 1'b0;
   logic [FIELD_W-1:0] csr_wr_data = '0;

   rollback_parity_union_find_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // model state
   logic [11:0]        forest_parent [NC][NODES];
   logic [3:0]         forest_rank   [NC][NODES];
   logic [11:0]        undo_child    [NC][NODES];
   logic [11:0]        undo_root     [NC][NODES];
   logic               undo_bump     [NC][NODES];
   logic [FIELD_W-1:0] undo_level    [NC];
   logic [FIELD_W-1:0] vertex_n = FIELD_W'(NV);

   logic [REQ_W-1:0] pending_reqs [$];
   logic [RSP_W-1:0] expected_rsps [$];
   int send_idle = 0;
   int recv_idle = 0;
   int errors = 0;

   initial forever #5 clock = ~clock;

   initial begin
      #50ms;
      $display("tb_rollback_parity_union_find_unit: errors");
      $finish;
   end

   function automatic int root_of(int c, int x);
      int steps = 0;
      while (forest_parent[c][x] != 12'(x) && steps < NODES) begin
         x = forest_parent[c][x] % NODES;
         steps++;
      end
      return x;
   endfunction

   function automatic void merge_trees(int c, int a, int b);
      int x = root_of(c, a);
      int y = root_of(c, b);
      int t;
      logic bump;
      if (x == y || undo_level[c] >= NODES) return;
      if (forest_rank[c][x] > forest_rank[c][y]) begin
         t = x; x = y; y = t;
      end
      bump = (forest_rank[c][x] == forest_rank[c][y]);
      undo_child[c][undo_level[c]] = 12'(x);
      undo_root[c][undo_level[c]]  = 12'(y);
      undo_bump[c][undo_level[c]]  = bump;
      undo_level[c]++;
      forest_parent[c][x] = 12'(y);
      forest_rank[c][y] = forest_rank[c][y] + 4'(bump);
   endfunction

   function automatic logic [RSP_W-1:0] apply_request(logic [REQ_W-1:0] r);
      logic [OPCODE_W-1:0] op = r[1:0];
      logic [COLOR_W-1:0] color = r[4:2];
      int u = r[15:5];
      int v = r[26:16];
      int target = r[37:27];
      int n = (vertex_n > NV) ? NV : vertex_n;
      int c, ch, rt;
      logic hit = 1'b0;
      logic ok;
      if (color == 0 || color > NC) return '0;
      c = color - 1;
      ok = (u >= 1 && u <= n && v >= 1 && v <= n);
      if (op == OP_ADD) begin
         if (ok) begin
            merge_trees(c, u - 1, v - 1 + n);
            merge_trees(c, u - 1 + n, v - 1);
         end
      end else if (op == OP_TEST) begin
         hit = ok && (root_of(c, u - 1) == root_of(c, v - 1));
      end else if (op == OP_ROLL) begin
         while (undo_level[c] > target) begin
            undo_level[c]--;
            ch = undo_child[c][undo_level[c]] % NODES;
            rt = undo_root[c][undo_level[c]] % NODES;
            forest_parent[c][ch] = 12'(ch);
            forest_rank[c][rt] = forest_rank[c][rt] - 4'(undo_bump[c][undo_level[c]]);
         end
      end
      return {4'b0, undo_level[c], hit};
   endfunction

   function automatic logic [REQ_W-1:0] pack_req(logic [1:0] op, int color, int a,
                                                 int b, int t);
      return {2'b0, 11'(t), 11'(b), 11'(a), 3'(color), op};
   endfunction

   function automatic void queue_req(logic [1:0] op, int color, int a, int b, int t);
      pending_reqs.insert(pending_reqs.size(), pack_req(op, color, a, b, t));
   endfunction

   // driver: predict on acceptance, then present the next request
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.insert(expected_rsps.size(), apply_request(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_reqs.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               if (errors < 10) $display("unexpected result %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tdata[0] !== want[0] || rsp_tdata[11:1] !== want[11:1]) begin
                  if (errors < 10)
                     $display("mismatch: conflict exp %0d got %0d, depth exp %0d got %0d",
                              want[0], rsp_tdata[0], want[11:1], rsp_tdata[11:1]);
                  errors++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_vertices(int value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= FIELD_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vertex_n = FIELD_W'(value);
   endtask

   task automatic random_run(int n, int count, int s_idle, int r_idle);
      int op, color, a, b, t, k;
      set_vertices(n);
      send_idle = s_idle;
      recv_idle = r_idle;
      for (k = 0; k < count; k++) begin
         op = $urandom_range(99);
         op = (op < 45) ? OP_ADD : (op < 80) ? OP_TEST : (op < 96) ? OP_ROLL : OP_SPARE;
         color = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(NC, 1);
         // mostly legal endpoints, sometimes any 11-bit value
         a = ($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(n, 1);
         b = ($urandom_range(15) == 0) ? $urandom_range(2047) : $urandom_range(n, 1);
         t = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(2 * n);
         queue_req(2'(op), color, a, b, t);
      end
      drain();
   endtask

   initial begin
      int c, i;
      for (c = 0; c < NC; c++) begin
         for (i = 0; i < NODES; i++) begin
            forest_parent[c][i] = 12'(i);
            forest_rank[c][i]   = 4'd1;
         end
         undo_level[c] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: odd triangle, extremes, bad colors and endpoints, spare op
      queue_req(OP_ADD, 1, 1, 2, 0);
      queue_req(OP_ADD, 1, 2, 3, 0);
      queue_req(OP_TEST, 1, 1, 3, 0);
      queue_req(OP_ADD, 1, 1, 3, 0);
      queue_req(OP_TEST, 1, 1, 3, 0);
      queue_req(OP_TEST, 2, 1, 3, 0);
      queue_req(OP_ADD, 4, 1024, 1, 0);
      queue_req(OP_TEST, 4, 1024, 1024, 0);
      queue_req(OP_ADD, 0, 5, 6, 0);
      queue_req(OP_ADD, 7, 5, 6, 2047);
      queue_req(OP_ADD, 2, 0, 6, 0);
      queue_req(OP_ADD, 2, 2047, 6, 0);
      queue_req(OP_SPARE, 1, 2047, 2047, 2047);
      queue_req(OP_ROLL, 1, 0, 0, 2047);
      queue_req(OP_ROLL, 1, 0, 0, 2);
      queue_req(OP_TEST, 1, 1, 3, 0);
      queue_req(OP_ROLL, 1, 0, 0, 0);
      queue_req(OP_TEST, 1, 1, 2, 0);
      drain();
      set_vertices(0);
      queue_req(OP_ADD, 1, 1, 2, 0);
      queue_req(OP_TEST, 1, 1, 2, 0);
      drain();
      set_vertices(2047);
      queue_req(OP_ADD, 3, 1024, 1023, 0);
      queue_req(OP_TEST, 3, 1024, 1023, 0);
      queue_req(OP_ROLL, 3, 0, 0, 0);
      drain();

      random_run(16, 500, 0, 0);
      random_run(5, 350, 66, 0);
      random_run(64, 450, 0, 66);
      random_run(1, 80, 16, 16);
      random_run(24, 400, 16, 16);
      random_run(1024, 80, 0, 0);

      if (expected_rsps.size() == 0 && errors == 0)
         $display("tb_rollback_parity_union_find_unit: clean");
      else
         $display("tb_rollback_parity_union_find_unit: errors");
      $finish;
   end
endmodule

>>> sim.f
hw/rtl/rpuf_pkg.sv
hw/rtl/rpuf_store.sv
hw/rtl/rpuf_undo.sv
hw/rtl/rollback_parity_union_find_unit.sv
tb/tb_rollback_parity_union_find_unit.sv
